// ----- sv/ppp_pkg.sv -----
// ppp_pkg: shared types, constants and helpers for the pinhole point projector
// no dependencies; used by the divider lane and the top level
package ppp_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0   = 3'd0,
    REG_ROT_ROW1   = 3'd1,
    REG_ROT_ROW2   = 3'd2,
    REG_TRANSLATE  = 3'd3,
    REG_FOCAL_SKEW = 3'd4,
    REG_PRINCIPAL  = 3'd5,
    REG_IMAGE_SIZE = 3'd6
  } reg_idx_t;

  // register reset values: identity rotation, unit focal lengths
  localparam logic [59:0] ROT_ROW0_RST = 60'd1 << 18;
  localparam logic [59:0] ROT_ROW1_RST = 60'd1 << 38;
  localparam logic [59:0] ROT_ROW2_RST = 60'd1 << 58;
  localparam logic [59:0] FOCAL_RST    = 60'd16777232;

  // fixed point constants
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // divider geometry: 35 quotient bits, one per stage
  localparam int DIV_STEPS = 35;
  localparam int REM_W     = 31;
  localparam int Q_W       = 35;
  // rounded quotient used when the true one saturates any pixel sum
  localparam logic [Q_W-1:0] Q_CLAMP = {2'b01, 33'd0};

  // pipeline stages: products, camera, intrinsics products, divide prep,
  // divider steps, output register
  localparam int S_DIV0 = 4;
  localparam int NS     = S_DIV0 + DIV_STEPS + 1;

  // item data that rides alongside the divider lanes
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               pos;
    logic               neg_u;
    logic               neg_v;
  } side_t;

  // saturate a 37-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/ppp_ifs.sv -----
// ppp_ifs: valid/ready channel interfaces for points, results and configuration
// depends on nothing but plain logic types
interface ppp_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  modport source(output valid, world_x, world_y, world_z, input ready);
  modport sink(input valid, world_x, world_y, world_z, output ready);
endinterface

interface ppp_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] camera_x;
  logic signed [31:0] camera_y;
  logic signed [31:0] camera_z;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               is_visible;
  modport source(output valid, camera_x, camera_y, camera_z, pixel_u, pixel_v,
                 is_visible, input ready);
  modport sink(input valid, camera_x, camera_y, camera_z, pixel_u, pixel_v,
               is_visible, output ready);
endinterface

interface ppp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/ppp_div_lane.sv -----
// ppp_div_lane: pipelined restoring divider, one quotient bit per stage,
// with round-half-up of the final bit; depends on ppp_pkg
module ppp_div_lane (
  input  logic                          clk,
  input  logic [ppp_pkg::DIV_STEPS-1:0] ld,
  input  logic [ppp_pkg::REM_W-1:0]     rem_in,
  input  logic [ppp_pkg::DIV_STEPS-1:0] bits_in,
  input  logic [ppp_pkg::REM_W-1:0]     div_in,
  input  logic                          ovf_in,
  output logic [ppp_pkg::Q_W-1:0]       q_out
);
  import ppp_pkg::*;

  logic [REM_W-1:0]     rem  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] bits [DIV_STEPS+1];
  logic [REM_W-1:0]     dvs  [DIV_STEPS+1];
  logic [Q_W-1:0]       quo  [DIV_STEPS+1];
  logic                 ovf  [DIV_STEPS+1];

  // stage zero sources come straight from the prep registers
  assign rem[0]  = rem_in;
  assign bits[0] = bits_in;
  assign dvs[0]  = div_in;
  assign quo[0]  = '0;
  assign ovf[0]  = ovf_in;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [REM_W:0]   trial;
    logic             ge;
    logic [REM_W:0]   diff;

    // shift in next dividend bit, compare and subtract
    always_comb begin
      trial = {rem[i], bits[i][DIV_STEPS-1]};
      ge    = trial >= {1'b0, dvs[i]};
      diff  = trial - {1'b0, dvs[i]};
    end

    always_ff @(posedge clk) begin
      if (ld[i]) begin
        rem[i+1]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        bits[i+1] <= {bits[i][DIV_STEPS-2:0], 1'b0};
        dvs[i+1]  <= dvs[i];
        quo[i+1]  <= {quo[i][Q_W-2:0], ge};
        ovf[i+1]  <= ovf[i];
      end
    end
  end

  // halve with rounding; clamp when the quotient ran out of bits
  logic [Q_W:0] q_inc;
  assign q_inc = {1'b0, quo[DIV_STEPS]} + {{Q_W{1'b0}}, 1'b1};
  assign q_out = ovf[DIV_STEPS] ? Q_CLAMP : q_inc[Q_W:1];

endmodule

// ----- sv/pinhole_point_projection.sv -----
// pinhole_point_projection: rigid transform, intrinsics and perspective divide
// one point per cycle sustained while results.ready stays high
// the 35-stage bit-per-stage divider sets the depth; stages stall independently
// rst (synchronous) clears all stage valid bits and restores register defaults
// depends on ppp_pkg, ppp_ifs and ppp_div_lane
module pinhole_point_projection (
  input logic      clk,
  input logic      rst,
  ppp_pt_if.sink   points,
  ppp_res_if.source results,
  ppp_cfg_if.sink  cfg
);
  import ppp_pkg::*;

  // configuration registers
  logic [59:0] rot_row [3];
  logic [62:0] trans;
  logic [59:0] focal;
  logic [63:0] ppt;
  logic [31:0] img;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= ROT_ROW0_RST;
      rot_row[1] <= ROT_ROW1_RST;
      rot_row[2] <= ROT_ROW2_RST;
      trans      <= '0;
      focal      <= FOCAL_RST;
      ppt        <= '0;
      img        <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ROT_ROW0:   rot_row[0] <= cfg.data[59:0];
        REG_ROT_ROW1:   rot_row[1] <= cfg.data[59:0];
        REG_ROT_ROW2:   rot_row[2] <= cfg.data[59:0];
        REG_TRANSLATE:  trans      <= cfg.data[62:0];
        REG_FOCAL_SKEW: focal      <= cfg.data[59:0];
        REG_PRINCIPAL:  ppt        <= cfg.data;
        REG_IMAGE_SIZE: img        <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // per-stage valid and ready chain, bubbles collapse
  logic [NS-1:0] v;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;
  logic [NS:0]   rdy;

  assign vin     = {v[NS-2:0], points.valid};
  assign rdy[NS] = results.ready;
  for (genvar i = 0; i < NS; i++) begin : g_ctl
    assign rdy[i] = !v[i] || rdy[i+1];
    assign ld[i]  = vin[i] && rdy[i];
  end
  assign points.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) v[i] <= vin[i];
      end
    end
  end

  // stage 0: rotation products
  logic signed [31:0] w [3];
  logic signed [51:0] prod [3][3];
  assign w[0] = points.world_x;
  assign w[1] = points.world_y;
  assign w[2] = points.world_z;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= $signed(rot_row[r][20*k +: 20]) * w[k];
        end
      end
    end
  end

  // stage 1: add translation, round, saturate
  logic signed [54:0] acc  [3];
  logic signed [31:0] cam1 [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = (55'($signed(trans[21*r +: 21])) <<< 26) + 55'(prod[r][0])
             + 55'(prod[r][1]) + 55'(prod[r][2]) + 55'sd131072;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int r = 0; r < 3; r++) begin
        cam1[r] <= sat32(acc[r][54:18]);
      end
    end
  end

  // stage 2: intrinsics products
  logic signed [31:0] cam2 [3];
  logic signed [52:0] pfx;
  logic signed [51:0] psk;
  logic signed [52:0] pfy;
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      cam2 <= cam1;
      pfx  <= $signed({1'b0, focal[19:0]}) * cam1[0];
      psk  <= $signed(focal[59:40]) * cam1[1];
      pfy  <= $signed({1'b0, focal[39:20]}) * cam1[1];
    end
  end

  // stage 3: numerators, magnitudes and divider setup
  logic signed [53:0] num_u, num_v, abs_u, abs_v;
  logic [REM_W-1:0]   zdiv;
  always_comb begin
    num_u = 54'(pfx) + 54'(psk);
    num_v = 54'(pfy);
    abs_u = num_u[53] ? -num_u : num_u;
    abs_v = num_v[53] ? -num_v : num_v;
    zdiv  = cam2[2][REM_W-1:0];
  end

  logic [REM_W-1:0]     du_rem, dv_rem, dz;
  logic [DIV_STEPS-1:0] du_bits, dv_bits;
  logic                 du_ovf, dv_ovf;
  side_t                sb [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      du_rem    <= {1'b0, abs_u[51:22]};
      dv_rem    <= {1'b0, abs_v[51:22]};
      du_bits   <= {abs_u[21:0], 13'd0};
      dv_bits   <= {abs_v[21:0], 13'd0};
      du_ovf    <= {1'b0, abs_u[51:22]} >= zdiv;
      dv_ovf    <= {1'b0, abs_v[51:22]} >= zdiv;
      dz        <= zdiv;
      sb[0].cx    <= cam2[0];
      sb[0].cy    <= cam2[1];
      sb[0].cz    <= cam2[2];
      sb[0].pos   <= cam2[2] > 32'sd0;
      sb[0].neg_u <= num_u[53];
      sb[0].neg_v <= num_v[53];
    end
  end

  // divider stages: sideband follows the lanes
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_sb
    always_ff @(posedge clk) begin
      if (ld[S_DIV0+j]) sb[j+1] <= sb[j];
    end
  end

  logic [Q_W-1:0] qu, qv;

  ppp_div_lane u_div_u (
    .clk     (clk),
    .ld      (ld[S_DIV0 +: DIV_STEPS]),
    .rem_in  (du_rem),
    .bits_in (du_bits),
    .div_in  (dz),
    .ovf_in  (du_ovf),
    .q_out   (qu)
  );

  ppp_div_lane u_div_v (
    .clk     (clk),
    .ld      (ld[S_DIV0 +: DIV_STEPS]),
    .rem_in  (dv_rem),
    .bits_in (dv_bits),
    .div_in  (dz),
    .ovf_in  (dv_ovf),
    .q_out   (qv)
  );

  // output stage: add principal point, saturate, visibility
  side_t              so;
  logic signed [36:0] su, sv;
  logic signed [31:0] u_n, v_n;
  logic               vis_n;
  always_comb begin
    so  = sb[DIV_STEPS];
    su  = so.neg_u ? $signed({5'd0, ppt[31:0]}) - $signed({2'd0, qu})
                   : $signed({5'd0, ppt[31:0]}) + $signed({2'd0, qu});
    sv  = so.neg_v ? $signed({5'd0, ppt[63:32]}) - $signed({2'd0, qv})
                   : $signed({5'd0, ppt[63:32]}) + $signed({2'd0, qv});
    u_n = so.pos ? sat32(su) : 32'sd0;
    v_n = so.pos ? sat32(sv) : 32'sd0;
    vis_n = so.pos && !u_n[31] && !v_n[31]
          && ($unsigned(u_n) < {img[15:0], 16'd0})
          && ($unsigned(v_n) < {img[31:16], 16'd0})
          && (so.cz > ONE_Q16);
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      results.camera_x   <= so.cx;
      results.camera_y   <= so.cy;
      results.camera_z   <= so.cz;
      results.pixel_u    <= u_n;
      results.pixel_v    <= v_n;
      results.is_visible <= vis_n;
    end
  end

  assign results.valid = v[NS-1];

  // checks
  a_vis_depth: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.is_visible |-> results.camera_z > ONE_Q16)
    else $error("visible point with depth not above one");

  a_vis_bounds: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.is_visible |-> !results.pixel_u[31] && !results.pixel_v[31])
    else $error("visible point with negative pixel");

  a_behind: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.camera_z <= 32'sd0 |->
      results.pixel_u == 32'sd0 && results.pixel_v == 32'sd0)
    else $error("pixel not zero for point behind camera");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> v[0])
    else $error("accepted transaction missing from first stage");

endmodule
